[src/etm_pkg.sv]
// Shared types, constants and the elaboration-time sine table generator
// for the Euler transform matrix builder. No dependencies.
package etm_pkg;

  localparam int unsigned SineTableBitsDef = 10;
  localparam logic [63:0] PihQ30 = 64'd1686629713;

  typedef logic signed [17:0] trig_t;

  typedef struct packed {
    logic [15:0]        angle_x;
    logic [15:0]        angle_y;
    logic [15:0]        angle_z;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] r0c0;
    logic signed [31:0] r0c1;
    logic signed [31:0] r0c2;
    logic signed [31:0] r0c3;
    logic signed [31:0] r1c0;
    logic signed [31:0] r1c1;
    logic signed [31:0] r1c2;
    logic signed [31:0] r1c3;
    logic signed [31:0] r2c0;
    logic signed [31:0] r2c1;
    logic signed [31:0] r2c2;
    logic signed [31:0] r2c3;
  } out_t;

  // One quarter-wave table entry: Taylor series of the sine in Q2.30,
  // rounded to Q16 and clamped. Evaluated only at elaboration.
  function automatic logic [16:0] quarter_sine(input int unsigned idx,
                                               input int unsigned bits);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] e;
    x    = (PihQ30 * 64'(idx)) >> bits;
    term = x;
    sum  = $signed(x);
    for (int k = 1; k <= 10; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) != 0) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    e = (sum + 64'sd8192) >>> 14;
    if (e > 64'sd65536) begin
      e = 64'sd65536;
    end
    if (idx == 0) begin
      e = 0;
    end
    if (idx == (32'd1 << bits)) begin
      e = 64'sd65536;
    end
    return e[16:0];
  endfunction

endpackage

[src/etm_sincos.sv]
// Sine and cosine of one binary angle from a quarter-wave constant table.
// Depends on etm_pkg for the table generator and the trig type.
module etm_sincos #(
  parameter int unsigned SINE_TABLE_BITS = etm_pkg::SineTableBitsDef
) (
  input  logic [15:0]    angle_i,
  output etm_pkg::trig_t sin_o,
  output etm_pkg::trig_t cos_o
);

  localparam int unsigned TblN = 1 << SINE_TABLE_BITS;

  logic [16:0] rom [TblN+1];

  for (genvar i = 0; i <= TblN; i++) begin : g_rom
    assign rom[i] = etm_pkg::quarter_sine(i, SINE_TABLE_BITS);
  end

  logic [15:0] cos_angle;
  assign cos_angle = angle_i + 16'd16384;

  function automatic etm_pkg::trig_t lookup(input logic [15:0] a,
                                            input logic [16:0] tbl [TblN+1]);
    logic [SINE_TABLE_BITS-1:0] j;
    logic [SINE_TABLE_BITS:0]   idx;
    logic [16:0]                v;
    j   = a[13 -: SINE_TABLE_BITS];
    idx = a[14] ? ((SINE_TABLE_BITS+1)'(TblN) - {1'b0, j}) : {1'b0, j};
    v   = tbl[idx];
    return a[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  assign sin_o = lookup(angle_i, rom);
  assign cos_o = lookup(cos_angle, rom);

endmodule

[src/euler_trs_matrix_build.sv]
// Throughput: one word per cycle while out_ready_i is high; every stage has
// its own valid bit and only stalls when the stage after it is full and
// stalled, so bubbles close up.
// Reset (rst_ni low, asynchronous) clears all valid bits; data registers are
// not reset. The sine table is constant logic and needs no initialization.
// Depends on etm_pkg and etm_sincos.
module euler_trs_matrix_build #(
  parameter int unsigned SINE_TABLE_BITS = etm_pkg::SineTableBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  etm_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output etm_pkg::out_t out_data_o
);

  // Stage 1: table lookups. Stage 2: pairwise trig products.
  // Stage 3: rotation entries in Q48. Stage 4: rounding to Q16.
  // Stage 5: multiply by the column scale. Stage 6: round and saturate.
  localparam int unsigned NumStages = 6;

  logic [NumStages:1] vld_q;
  logic [NumStages:1] en;

  // A stage loads when it is empty or when its word moves on this cycle.
  always_comb begin
    en[NumStages] = !vld_q[NumStages] || out_ready_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[1];
  assign out_valid_o = vld_q[NumStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) begin
        vld_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Translation and scale ride along with the word. Entry k belongs to
  // stage k+1; the scale is needed only up to the multiply stage.
  logic signed [31:0] trans_q [NumStages][3];
  logic signed [31:0] scale_q [NumStages-2][3];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      trans_q[0][0] <= in_data_i.trans_x;
      trans_q[0][1] <= in_data_i.trans_y;
      trans_q[0][2] <= in_data_i.trans_z;
      scale_q[0][0] <= in_data_i.scale_x;
      scale_q[0][1] <= in_data_i.scale_y;
      scale_q[0][2] <= in_data_i.scale_z;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k+1]) begin
        trans_q[k] <= trans_q[k-1];
      end
    end
    for (int k = 1; k < NumStages - 2; k++) begin
      if (en[k+1]) begin
        scale_q[k] <= scale_q[k-1];
      end
    end
  end

  // ---------------- Stage 1: sine and cosine lookups ----------------
  etm_pkg::trig_t sx_d, cx_d, sy_d, cy_d, sz_d, cz_d;
  etm_pkg::trig_t sx_q, cx_q, sy_q, cy_q, sz_q, cz_q;

  etm_sincos #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sc_x (
    .angle_i(in_data_i.angle_x), .sin_o(sx_d), .cos_o(cx_d)
  );
  etm_sincos #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sc_y (
    .angle_i(in_data_i.angle_y), .sin_o(sy_d), .cos_o(cy_d)
  );
  etm_sincos #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sc_z (
    .angle_i(in_data_i.angle_z), .sin_o(sz_d), .cos_o(cz_d)
  );

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sx_q <= sx_d;
      cx_q <= cx_d;
      sy_q <= sy_d;
      cy_q <= cy_d;
      sz_q <= sz_d;
      cz_q <= cz_d;
    end
  end

  // ---------------- Stage 2: products of two trig values ----------------
  logic signed [35:0] czsy_q, szsy_q, czcy_q, szcy_q, szcx_q, szsx_q;
  logic signed [35:0] czcx_q, czsx_q, cysx_q, cycx_q;
  etm_pkg::trig_t     sx2_q, cx2_q, sy2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      czsy_q <= cz_q * sy_q;
      szsy_q <= sz_q * sy_q;
      czcy_q <= cz_q * cy_q;
      szcy_q <= sz_q * cy_q;
      szcx_q <= sz_q * cx_q;
      szsx_q <= sz_q * sx_q;
      czcx_q <= cz_q * cx_q;
      czsx_q <= cz_q * sx_q;
      cysx_q <= cy_q * sx_q;
      cycx_q <= cy_q * cx_q;
      sx2_q  <= sx_q;
      cx2_q  <= cx_q;
      sy2_q  <= sy_q;
    end
  end

  // ---------------- Stage 3: rotation entries in Q48 ----------------
  // Entries in row-major order without the translation column.
  logic signed [53:0] e_d [9];
  logic signed [53:0] e_q [9];

  function automatic logic signed [53:0] up16(input logic signed [35:0] v);
    return 54'(v) <<< 16;
  endfunction

  always_comb begin
    e_d[0] = up16(czcy_q);
    e_d[1] = 54'(czsy_q * sx2_q) - up16(szcx_q);
    e_d[2] = 54'(czsy_q * cx2_q) + up16(szsx_q);
    e_d[3] = up16(szcy_q);
    e_d[4] = 54'(szsy_q * sx2_q) + up16(czcx_q);
    e_d[5] = 54'(szsy_q * cx2_q) - up16(czsx_q);
    e_d[6] = -(54'(sy2_q) <<< 32);
    e_d[7] = up16(cysx_q);
    e_d[8] = up16(cycx_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      e_q <= e_d;
    end
  end

  // ---------------- Stage 4: round entries to Q16 ----------------
  logic signed [21:0] r_q [9];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int i = 0; i < 9; i++) begin
        r_q[i] <= 22'((e_q[i] + 54'sd2147483648) >>> 32);
      end
    end
  end

  // ---------------- Stage 5: multiply by the column scale ----------------
  logic signed [53:0] p_q [9];

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int i = 0; i < 9; i++) begin
        p_q[i] <= 54'(r_q[i]) * 54'(scale_q[3][i % 3]);
      end
    end
  end

  // ---------------- Stage 6: round, saturate, output register ----------------
  logic signed [31:0] m_d [9];
  logic signed [31:0] m_q [9];

  always_comb begin
    logic signed [37:0] t;
    for (int i = 0; i < 9; i++) begin
      t = 38'((p_q[i] + 54'sd32768) >>> 16);
      if (t > 38'sd2147483647) begin
        m_d[i] = 32'sh7FFFFFFF;
      end else if (t < -38'sd2147483648) begin
        m_d[i] = 32'sh80000000;
      end else begin
        m_d[i] = t[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      m_q <= m_d;
    end
  end

  assign out_data_o.r0c0 = m_q[0];
  assign out_data_o.r0c1 = m_q[1];
  assign out_data_o.r0c2 = m_q[2];
  assign out_data_o.r0c3 = trans_q[5][0];
  assign out_data_o.r1c0 = m_q[3];
  assign out_data_o.r1c1 = m_q[4];
  assign out_data_o.r1c2 = m_q[5];
  assign out_data_o.r1c3 = trans_q[5][1];
  assign out_data_o.r2c0 = m_q[6];
  assign out_data_o.r2c1 = m_q[7];
  assign out_data_o.r2c2 = m_q[8];
  assign out_data_o.r2c3 = trans_q[5][2];

endmodule

[src/etm_checker.sv]
// Port-level checks for the Euler transform matrix builder, bound to the
// top level. Depends on etm_pkg for the word types.
module etm_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input etm_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input etm_pkg::out_t out_data_o
);

  // A stalled output word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A stalled output word does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output word changed while stalled");

  // With the output register empty, no stage can be blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // The handshake outputs are always known once out of reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({out_valid_o, in_ready_o}))
    else $error("handshake output unknown");

  // A waiting input word stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input word changed while waiting");

endmodule

bind euler_trs_matrix_build etm_checker u_etm_checker (.*);

[sim/euler_trs_matrix_build_tb.sv]
// Self-checking testbench for euler_trs_matrix_build: directed and random words,
// with random stalls on both sides. Depends on etm_pkg and the block's RTL.
`timescale 1ns / 100ps

module euler_trs_matrix_build_tb;

  localparam int unsigned TableBits = etm_pkg::SineTableBitsDef;
  localparam int unsigned TableSize = 1 << TableBits;
  localparam int          NumRandom = 1230;
  localparam int          QuietFrom = 1000;
  localparam int          StallLimit = 5000;

  // Predicts each matrix from the angles, translation and scale,
  // and holds the predicted words until the block delivers them.
  class matrix_scoreboard;
    longint        quarter_sine[TableSize + 1];
    etm_pkg::out_t pending[$];
    int            errors;
    string         field_name[12] = '{"r2c3", "r2c2", "r2c1", "r2c0", "r1c3", "r1c2",
                                      "r1c1", "r1c0", "r0c3", "r0c2", "r0c1", "r0c0"};

    function new();
      longint unsigned x;
      longint unsigned term;
      longint          sum;
      errors = 0;
      for (int i = 0; i <= TableSize; i++) begin
        x    = (64'd1686629713 * longint'(i)) / TableSize;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 10; k++) begin
          term = (term * x) >> 30;
          term = (term * x) >> 30;
          term = term / longint'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) sum -= longint'(term);
          else sum += longint'(term);
        end
        if (sum < 0) sum = 0;
        sum = (sum + 8192) / 16384;
        quarter_sine[i] = (sum > 65536) ? 65536 : sum;
      end
      quarter_sine[0]         = 0;
      quarter_sine[TableSize] = 65536;
    endfunction

    function longint sine(logic [15:0] a);
      int unsigned j;
      longint      v;
      j = a[13:0] >> (14 - TableBits);
      v = a[14] ? quarter_sine[TableSize - j] : quarter_sine[j];
      return a[15] ? -v : v;
    endfunction

    function longint cosine(logic [15:0] a);
      return sine(a + 16'd16384);
    endfunction

    // Round a Q48 rotation entry to Q16, apply the column scale, saturate.
    function logic [31:0] scaled(longint e48, logic signed [31:0] s);
      longint r;
      longint p;
      r = (e48 + (64'sd1 <<< 31)) >>> 32;
      p = (r * longint'(s) + 64'sd32768) >>> 16;
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return p[31:0];
    endfunction

    function void note_input(etm_pkg::in_t w);
      longint        sx, cx, sy, cy, sz, cz;
      longint        one;
      etm_pkg::out_t m;
      one = 65536;
      sx = sine(w.angle_x); cx = cosine(w.angle_x);
      sy = sine(w.angle_y); cy = cosine(w.angle_y);
      sz = sine(w.angle_z); cz = cosine(w.angle_z);
      m.r0c0 = scaled(cz * cy * one, w.scale_x);
      m.r0c1 = scaled(cz * sy * sx - sz * cx * one, w.scale_y);
      m.r0c2 = scaled(cz * sy * cx + sz * sx * one, w.scale_z);
      m.r0c3 = w.trans_x;
      m.r1c0 = scaled(sz * cy * one, w.scale_x);
      m.r1c1 = scaled(sz * sy * sx + cz * cx * one, w.scale_y);
      m.r1c2 = scaled(sz * sy * cx - cz * sx * one, w.scale_z);
      m.r1c3 = w.trans_y;
      m.r2c0 = scaled(-sy * one * one, w.scale_x);
      m.r2c1 = scaled(cy * sx * one, w.scale_y);
      m.r2c2 = scaled(cy * cx * one, w.scale_z);
      m.r2c3 = w.trans_z;
      pending.push_back(m);
    endfunction

    function void check_result(etm_pkg::out_t got);
      logic [11:0][31:0] want_f;
      logic [11:0][31:0] got_f;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected output word %h", $time, got);
        return;
      end
      want_f = pending.pop_front();
      got_f  = got;
      for (int k = 0; k < 12; k++) begin
        if (want_f[k] !== got_f[k]) begin
          errors++;
          if (errors < 60)
            $display("%0t: %s expected %h actual %h", $time, field_name[k],
                     want_f[k], got_f[k]);
        end
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  etm_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  etm_pkg::out_t out_data;

  matrix_scoreboard sb = new();
  bit   quiet = 1'b0;
  int   idle_cycles = 0;

  always #6 clk = ~clk;

  euler_trs_matrix_build u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // Output side: every accepted word is checked against the oldest prediction.
  // The watchdog counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: one long hold-off early on so the pipeline fills and pushes
  // back on the sender, then random stalls, then always ready near the end.
  initial begin
    @(posedge rst_n);
    repeat (40) @(posedge clk);
    out_ready <= 1'b0;
    repeat (300) @(posedge clk);
    while (!quiet) begin
      if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    out_ready <= 1'b1;
  end

  // Offers one word and holds it until the block takes it. The caller either
  // offers the next word or drops valid on the following edge.
  task automatic send_word(input etm_pkg::in_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Scales are mostly modest so the matrix stays in range, but full-range
  // values turn up often enough to drive saturation at both ends.
  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'h0000} ^ $urandom;
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  initial begin
    etm_pkg::in_t w;
    logic [15:0]  angles[6];
    logic [31:0]  scales[5];
    angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2AAA};
    scales = '{32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'h00010000, 32'hFFFF0000};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: quadrant boundaries, the last angle code, unity and
    // extreme scales (saturation), extreme translations passed through.
    for (int i = 0; i < 20; i++) begin
      w.angle_x = angles[i % 6];
      w.angle_y = angles[(i / 2) % 6];
      w.angle_z = angles[(i + 3) % 6];
      w.trans_x = (i % 2) ? 32'h7FFFFFFF : 32'h80000000;
      w.trans_y = (i % 3) ? 32'h00000000 : 32'hFFFFFFFF;
      w.trans_z = $urandom;
      w.scale_x = scales[i % 5];
      w.scale_y = scales[(i + 1) % 5];
      w.scale_z = scales[(i + 2) % 5];
      send_word(w);
    end

    for (int i = 0; i < NumRandom; i++) begin
      if (i == QuietFrom) quiet = 1'b1;
      maybe_gap();
      w.angle_x = $urandom;
      w.angle_y = $urandom;
      w.angle_z = $urandom;
      w.trans_x = $urandom;
      w.trans_y = $urandom;
      w.trans_z = $urandom;
      w.scale_x = pick_scale();
      w.scale_y = pick_scale();
      w.scale_z = pick_scale();
      send_word(w);
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
